FILE: rtl/core/stfl_pkg.sv
package stfl_pkg;

	localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;
	localparam int unsigned LEN_CFG_W = 11;
	localparam int unsigned IDX_W = 10;
	localparam int unsigned WORD_W = 32;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic                     kind;
		logic [IDX_W-1:0]         entry_index;
		logic signed [WORD_W-1:0] word;
	} in_req_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] last_index;
	} out_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOWER,
		ST_UPPER,
		ST_DONE
	} st_t;

endpackage

FILE: rtl/core/stfl_ram.sv
module stfl_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/stfl_seq.sv
module stfl_seq #(
	parameter int unsigned TABLE_DEPTH = stfl_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  stfl_pkg::in_req_t            in_data,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0] used_len,
	output logic                         out_valid,
	input  logic                         out_stall,
	output stfl_pkg::out_rsp_t           out_data,
	output logic                         ram_we,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
	output logic [stfl_pkg::WORD_W-1:0]  ram_wdata,
	output logic                         ram_re,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
	input  logic [stfl_pkg::WORD_W-1:0]  ram_rdata
);

	import stfl_pkg::*;

	localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
	localparam int unsigned LEN_W = $clog2(TABLE_DEPTH + 1);

	st_t state_q, state_d;

	logic [LEN_W-1:0]         lo_q, hi_q, n_q, mid_q, first_q, last_q;
	logic signed [WORD_W-1:0] key_q;
	logic                     rd_pend_q, eq_q, found_q;
	logic                     out_valid_q;
	out_rsp_t                 out_data_q;

	logic [LEN_W-1:0] lo_n, hi_n, mid_n;
	logic             eq_n, go_right, more, found_lb, out_free, in_take;

	assign out_free = !out_valid_q || !out_stall;
	assign in_take = (state_q == ST_IDLE) && in_valid;

	// one probe step: fold in the data of last cycle's read, then pick the next midpoint
	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		eq_n = eq_q;
		go_right = 1'b0;
		if (rd_pend_q) begin
			if (state_q == ST_UPPER) begin
				go_right = $signed(ram_rdata) <= key_q;
			end else begin
				go_right = $signed(ram_rdata) < key_q;
			end
			if (go_right) begin
				lo_n = mid_q + LEN_W'(1);
			end else begin
				hi_n = mid_q;
				eq_n = $signed(ram_rdata) == key_q;
			end
		end
		more = lo_n < hi_n;
		mid_n = lo_n + ((hi_n - lo_n) >> 1);
		// hi only ever drops to a probed entry, so hi below n means its value was seen
		found_lb = (hi_n != n_q) && eq_n;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_data.kind == KIND_QUERY) begin
					state_d = ST_LOWER;
				end
			end
			ST_LOWER: begin
				if (!more) begin
					state_d = found_lb ? ST_UPPER : ST_DONE;
				end
			end
			ST_UPPER: begin
				if (!more) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		ram_re = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_stall = 1'b0;
			ST_LOWER: ram_re = more;
			ST_UPPER: ram_re = more;
			ST_DONE:  in_stall = 1'b1;
			default:  in_stall = 1'b1;
		endcase
		ram_raddr = mid_n[ADDR_W-1:0];
		ram_we = in_take && (in_data.kind == KIND_WRITE)
			&& (32'(in_data.entry_index) < 32'(TABLE_DEPTH));
		ram_waddr = ADDR_W'(in_data.entry_index);
		ram_wdata = in_data.word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q) inside
				ST_LOWER, ST_UPPER: rd_pend_q <= more && !(state_q == ST_LOWER && !more);
				default:            rd_pend_q <= 1'b0;
			endcase
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				key_q <= in_data.word;
				n_q <= used_len;
				lo_q <= '0;
				hi_q <= used_len;
				eq_q <= 1'b0;
			end
			ST_LOWER: begin
				mid_q <= mid_n;
				if (more) begin
					lo_q <= lo_n;
					hi_q <= hi_n;
					eq_q <= eq_n;
				end else begin
					// restart over the whole used range for the upper bound
					lo_q <= '0;
					hi_q <= n_q;
					found_q <= found_lb;
					first_q <= found_lb ? lo_n : '0;
					last_q <= '0;
				end
			end
			ST_UPPER: begin
				mid_q <= mid_n;
				lo_q <= lo_n;
				hi_q <= hi_n;
				eq_q <= eq_n;
				if (!more) begin
					last_q <= (lo_n > first_q) ? LEN_W'(lo_n - LEN_W'(1)) : first_q;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_data_q.found <= found_q;
					out_data_q.first_index <= IDX_W'(first_q);
					out_data_q.last_index <= IDX_W'(last_q);
				end
			end
			default: begin
				lo_q <= lo_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

FILE: rtl/core/sorted_table_first_last_search.sv
// Channel   Dir   Payload               Accepted when
// in        in    stfl_pkg::in_req_t    in_valid & !in_stall
// out       out   stfl_pkg::out_rsp_t   out_valid & !out_stall
// cfg       in    table_length, 11 b    cfg_we
//
// A write request is taken from idle straight into the table and gives no response.
// A query request holds the block through its searches until its response is loaded
// into the output register: one table read per probe, and both bound searches share
// the single RAM read port.
// Reset clears the control state and table_length; table contents stay undefined.
// A response waiting on out_stall lets write requests through; the next query
// finishes its searches and then holds until the output register is free.
module sorted_table_first_last_search #(
	parameter int unsigned TABLE_DEPTH = stfl_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  stfl_pkg::in_req_t                in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output stfl_pkg::out_rsp_t               out_data,
	input  logic                             cfg_we,
	input  logic [stfl_pkg::LEN_CFG_W-1:0]   cfg_wdata
);

	import stfl_pkg::*;

	localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
	localparam int unsigned LEN_W = $clog2(TABLE_DEPTH + 1);

	// table_length register
	logic [LEN_CFG_W-1:0] table_length_q;
	logic [LEN_W-1:0]     used_len;

	// RAM ports
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= '0;
		end else if (cfg_we) begin
			table_length_q <= cfg_wdata;
		end
	end

	// lengths beyond the table depth search the whole table
	always_comb begin
		if (32'(table_length_q) > 32'(TABLE_DEPTH)) begin
			used_len = LEN_W'(TABLE_DEPTH);
		end else begin
			used_len = LEN_W'(table_length_q);
		end
	end

	// sequencer: writes go straight to the RAM from idle; queries run a lower-bound
	// search, then, if the key was seen, an upper-bound search over the same range.
	// Reads and writes never share a cycle, so no forwarding is needed.
	stfl_seq #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.used_len (used_len),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	// sorted table, stored as written
	stfl_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// a table write only ever happens on an accepted request
	a_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (in_valid && !in_stall))
		else $error("table write without accepted request");

	// searches never collide with writes
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("table read and write in the same cycle");

	// probes stay inside the used part of the table
	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (32'(ram_raddr) < 32'(used_len)))
		else $error("probe beyond used length");

	// a miss reports zero indices
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.found) |->
			(out_data.first_index == '0 && out_data.last_index == '0))
		else $error("miss with non-zero indices");

endmodule
